### design/xfcp_pkg.sv
// package for the xor framed command parser
// holds the phase and event types, protocol constants and register indexes
// no dependencies
`timescale 1ns / 1ps

package xfcp_pkg;

   localparam logic [7:0] START_RESET = 8'h6D;
   localparam logic [7:0] END_RESET   = 8'h29;
   localparam logic [7:0] REPLY_SIZE  = 8'h0D;
   localparam logic [7:0] REPLY_TAG   = 8'h03;
   localparam logic [7:0] CMD_REPORT  = 8'h01;
   localparam logic [7:0] CMD_PWM     = 8'h02;
   localparam logic [7:0] CODE_NR     = 8'h88;
   localparam logic [7:0] CODE_BAD    = 8'h99;

   localparam logic       CSR_START   = 1'b0;
   localparam logic       CSR_END     = 1'b1;

   localparam logic [1:0] KIND_REPLY  = 2'd0;
   localparam logic [1:0] KIND_REPORT = 2'd1;
   localparam logic [1:0] KIND_PWM    = 2'd2;

   localparam int         HEAD_DEPTH  = 3;
   localparam logic [2:0] REPLY_LAST  = 3'd5;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_LEN  = 3'd1,
      PH_CMD  = 3'd2,
      PH_DATA = 3'd3,
      PH_SUM  = 3'd4,
      PH_END  = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      EVT_REPORT = 2'd0,
      EVT_PWM    = 2'd1,
      EVT_REPLY  = 2'd2
   } evt_type;

   // one finished frame handed from parser to emitter
   typedef struct packed {
      logic        valid;
      evt_type     evt;
      logic [7:0]  code;
      logic [7:0]  duty;
      logic [15:0] duration;
   } frame_evt_type;

endpackage

### design/xor_framed_command_parser_unit.sv
// Framed command parser with XOR checksum. Takes one received byte per cycle on the req
// stream, save while an end byte waits, and at each frame's end byte sends either one
// command word (report request or pwm load) or a six word reply frame (BAD on end-byte or
// checksum error, NR on unknown command) on the rsp stream. The first result word of a
// frame is offered in the cycle after its end byte is taken. Only the end byte of a frame
// waits for the emitter to finish the previous frame's words: with an always ready receiver,
// a reply frame can hold back the end byte of a shortest following frame, and every stall
// on rsp holds it back longer. The start and end markers are written through the csr port.
// depends on xfcp_pkg, xfcp_parser, xfcp_emitter
`timescale 1ns / 1ps

module xor_framed_command_parser_unit
   import xfcp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [7:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // reply_byte, duty_value, duration_ticks
   output logic [1:0]  rsp_tuser,   // kind
   output logic        rsp_tlast    // reply_last
);

   logic [7:0]    start_ff;
   logic [7:0]    end_ff;
   logic          emit_free;
   frame_evt_type evt;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= START_RESET;
         end_ff   <= END_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_START: start_ff <= csr_wdata;
            CSR_END:   end_ff   <= csr_wdata;
            default:   start_ff <= start_ff;
         endcase
      end
   end

   xfcp_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .byte_valid   (req_tvalid),
      .byte_data    (req_tdata),
      .emit_free    (emit_free),
      .start_marker (start_ff),
      .end_marker   (end_ff),
      .byte_ready   (req_tready),
      .evt_out      (evt)
   );

   xfcp_emitter u_emitter (
      .clock        (clock),
      .reset        (reset),
      .evt_in       (evt),
      .start_marker (start_ff),
      .end_marker   (end_ff),
      .emit_free    (emit_free),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

### design/xfcp_parser.sv
// frame parser: phase machine, running xor and data head capture
// depends on xfcp_pkg
`timescale 1ns / 1ps

module xfcp_parser
   import xfcp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          byte_valid,
   input  logic [7:0]    byte_data,
   input  logic          emit_free,
   input  logic [7:0]    start_marker,
   input  logic [7:0]    end_marker,
   output logic          byte_ready,
   output frame_evt_type evt_out
);

   phase_type  phase_ff, phase_in;
   logic [7:0] left_ff, left_in;
   logic [7:0] cmd_ff, cmd_in;
   logic [7:0] xor_ff, xor_in;
   logic [7:0] sum_ff, sum_in;
   logic [1:0] seen_ff, seen_in;
   logic [7:0] head_ff [HEAD_DEPTH];
   logic [7:0] head_in [HEAD_DEPTH];
   logic       accept;

   // only the end byte produces results, so only it waits on the emitter
   assign byte_ready = (phase_ff != PH_END) || emit_free;
   assign accept     = byte_valid && byte_ready;

   always_comb begin
      phase_in = phase_ff;
      left_in  = left_ff;
      cmd_in   = cmd_ff;
      xor_in   = xor_ff;
      sum_in   = sum_ff;
      seen_in  = seen_ff;
      for (int i = 0; i < HEAD_DEPTH; i++) head_in[i] = head_ff[i];
      evt_out          = '0;
      evt_out.evt      = EVT_REPORT;
      if (accept) begin
         unique case (phase_ff)
            PH_LEN: begin
               left_in  = byte_data;
               xor_in   = xor_ff ^ byte_data;
               seen_in  = 2'd0;
               for (int i = 0; i < HEAD_DEPTH; i++) head_in[i] = 8'h00;
               phase_in = PH_CMD;
            end
            PH_CMD: begin
               cmd_in   = byte_data;
               xor_in   = xor_ff ^ byte_data;
               phase_in = (left_ff == 8'h00) ? PH_SUM : PH_DATA;
            end
            PH_DATA: begin
               if (seen_ff != 2'd3) begin
                  head_in[seen_ff] = byte_data;
                  seen_in          = seen_ff + 2'd1;
               end
               xor_in  = xor_ff ^ byte_data;
               left_in = left_ff - 8'd1;
               if (left_ff == 8'd1) phase_in = PH_SUM;
            end
            PH_SUM: begin
               sum_in   = byte_data;
               phase_in = PH_END;
            end
            PH_END: begin
               phase_in      = PH_IDLE;
               evt_out.valid = 1'b1;
               // end byte is checked ahead of the checksum
               if (byte_data != end_marker || sum_ff != xor_ff) begin
                  evt_out.evt  = EVT_REPLY;
                  evt_out.code = CODE_BAD;
               end else if (cmd_ff == CMD_REPORT) begin
                  evt_out.evt = EVT_REPORT;
               end else if (cmd_ff == CMD_PWM) begin
                  evt_out.evt      = EVT_PWM;
                  evt_out.duty     = head_ff[0];
                  evt_out.duration = {head_ff[1], head_ff[2]};
               end else begin
                  evt_out.evt  = EVT_REPLY;
                  evt_out.code = CODE_NR;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               if (byte_data == start_marker) begin
                  xor_in   = byte_data;
                  phase_in = PH_LEN;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         left_ff  <= '0;
         cmd_ff   <= '0;
         xor_ff   <= '0;
         sum_ff   <= '0;
         seen_ff  <= '0;
         for (int i = 0; i < HEAD_DEPTH; i++) head_ff[i] <= '0;
      end else begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         cmd_ff   <= cmd_in;
         xor_ff   <= xor_in;
         sum_ff   <= sum_in;
         seen_ff  <= seen_in;
         for (int i = 0; i < HEAD_DEPTH; i++) head_ff[i] <= head_in[i];
      end
   end

endmodule

### design/xfcp_emitter.sv
// result emitter: holds one frame event and sends its result words
// depends on xfcp_pkg
`timescale 1ns / 1ps

module xfcp_emitter
   import xfcp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  frame_evt_type evt_in,
   input  logic [7:0]    start_marker,
   input  logic [7:0]    end_marker,
   output logic          emit_free,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [31:0]   rsp_tdata,
   output logic [1:0]    rsp_tuser,
   output logic          rsp_tlast
);

   logic        valid_ff, valid_in;
   logic [2:0]  idx_ff, idx_in;
   evt_type     evt_ff;
   logic [7:0]  code_ff;
   logic [7:0]  duty_ff;
   logic [15:0] dur_ff;
   logic        last_word;
   logic        done;
   logic [7:0]  reply_byte;
   logic [7:0]  header_xor;

   assign last_word = (evt_ff != EVT_REPLY) || (idx_ff == REPLY_LAST);
   assign done      = valid_ff && rsp_tready && last_word;
   assign emit_free = !valid_ff || done;

   assign header_xor = start_marker ^ REPLY_SIZE ^ REPLY_TAG ^ code_ff;

   always_comb begin
      unique case (idx_ff)
         3'd0:    reply_byte = start_marker;
         3'd1:    reply_byte = REPLY_SIZE;
         3'd2:    reply_byte = REPLY_TAG;
         3'd3:    reply_byte = code_ff;
         3'd4:    reply_byte = header_xor;
         3'd5:    reply_byte = end_marker;
         default: reply_byte = 8'h00;
      endcase
   end

   always_comb begin
      rsp_tvalid = valid_ff;
      rsp_tlast  = 1'b0;
      rsp_tuser  = KIND_REPLY;
      rsp_tdata  = '0;
      unique case (evt_ff)
         EVT_REPLY: begin
            rsp_tdata[7:0] = reply_byte;
            rsp_tlast      = (idx_ff == REPLY_LAST);
         end
         EVT_REPORT: rsp_tuser = KIND_REPORT;
         EVT_PWM: begin
            rsp_tuser        = KIND_PWM;
            rsp_tdata[15:8]  = duty_ff;
            rsp_tdata[31:16] = dur_ff;
         end
         default: rsp_tuser = KIND_REPLY;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (evt_in.valid) begin
         valid_in = 1'b1;
         idx_in   = 3'd0;
      end else if (valid_ff && rsp_tready) begin
         if (last_word) valid_in = 1'b0;
         else           idx_in   = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (evt_in.valid) begin
         evt_ff  <= evt_in.evt;
         code_ff <= evt_in.code;
         duty_ff <= evt_in.duty;
         dur_ff  <= evt_in.duration;
      end
   end

   // a new frame event only arrives when the previous one is drained
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      evt_in.valid |-> emit_free)
      else $error("frame event while emitter busy");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> idx_ff <= REPLY_LAST)
      else $error("reply index out of range");

   a_single_word: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && evt_ff != EVT_REPLY) |-> idx_ff == 3'd0)
      else $error("command result advanced past first word");

   a_reply_steps: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_tready && !last_word && !evt_in.valid) |=>
         (valid_ff && idx_ff == $past(idx_ff) + 3'd1))
      else $error("reply frame skipped or repeated a byte");

endmodule

### verif/tb_xor_framed_command_parser_unit.sv
// testbench for xor_framed_command_parser_unit: byte frames in on req, result words out on rsp
// a software frame parser predicts every word, which the monitor checks in order
// depends on xfcp_pkg and the design files
`timescale 1ns / 1ps

module tb_xor_framed_command_parser_unit;
   import xfcp_pkg::*;

   localparam int LONG_HOLD = 150;
   localparam int SETTLE_CYCLES = 20;

   typedef enum logic [1:0] {
      FLAW_NONE,
      FLAW_SUM,
      FLAW_END,
      FLAW_CUT
   } flaw_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  reply;
      logic        last;
      logic [7:0]  duty;
      logic [15:0] ticks;
   } rsp_word_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic        csr_addr = CSR_START;
   logic [7:0]  csr_wdata = 8'h00;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // reply_byte, duty_value, duration_ticks
   logic [1:0]  rsp_tuser;          // kind
   logic        rsp_tlast;          // reply_last

   // shadow of the marker registers
   logic [7:0]  start_mark = START_RESET;
   logic [7:0]  end_mark = END_RESET;

   // frame parser state
   phase_type   frm_phase = PH_IDLE;
   logic [7:0]  left_cnt = 8'h00;
   logic [7:0]  cmd_byte = 8'h00;
   logic [7:0]  xor_acc = 8'h00;
   logic [7:0]  head [3] = '{8'h00, 8'h00, 8'h00};
   logic [1:0]  head_cnt = 2'd0;
   logic [7:0]  sum_byte = 8'h00;

   logic [7:0]   rx_stream [$];
   rsp_word_type due_words [$];

   int bytes_queued = 0;
   int bytes_taken = 0;
   int frame_bytes = 0;
   int frames_sent = 0;
   int words_seen = 0;
   int reg_writes = 0;
   int errors = 0;

   int tx_wait = 0;
   int stall_left = 0;
   int hold_left = 0;
   int hold_asks = 0;
   int hold_done = 0;
   bit tx_burst = 0;
   bit rx_burst = 0;

   rsp_word_type got;
   rsp_word_type want;

   xor_framed_command_parser_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void queue_reply(logic [7:0] code);
      logic [7:0] f [6];
      f[0] = start_mark;
      f[1] = REPLY_SIZE;
      f[2] = REPLY_TAG;
      f[3] = code;
      f[4] = f[0] ^ f[1] ^ f[2] ^ f[3];
      f[5] = end_mark;
      for (int k = 0; k < 6; k++)
         due_words.push_back('{KIND_REPLY, f[k], (k == 5), 8'h00, 16'h0000});
   endfunction

   // advance the frame parser by one byte and queue any words it produces
   function automatic void parse_byte(logic [7:0] b);
      case (frm_phase)
         PH_LEN: begin
            left_cnt = b;
            xor_acc ^= b;
            head_cnt = 2'd0;
            head = '{8'h00, 8'h00, 8'h00};
            frm_phase = PH_CMD;
         end
         PH_CMD: begin
            cmd_byte = b;
            xor_acc ^= b;
            frm_phase = (left_cnt == 8'h00) ? PH_SUM : PH_DATA;
         end
         PH_DATA: begin
            if (head_cnt < 2'd3) begin
               head[head_cnt] = b;
               head_cnt++;
            end
            xor_acc ^= b;
            left_cnt--;
            if (left_cnt == 8'h00)
               frm_phase = PH_SUM;
         end
         PH_SUM: begin
            sum_byte = b;
            frm_phase = PH_END;
         end
         PH_END: begin
            frm_phase = PH_IDLE;
            // end byte is judged before the checksum
            if (b != end_mark || sum_byte != xor_acc)
               queue_reply(CODE_BAD);
            else if (cmd_byte == CMD_REPORT)
               due_words.push_back('{KIND_REPORT, 8'h00, 1'b0, 8'h00, 16'h0000});
            else if (cmd_byte == CMD_PWM)
               due_words.push_back('{KIND_PWM, 8'h00, 1'b0, head[0], {head[1], head[2]}});
            else
               queue_reply(CODE_NR);
         end
         default: begin
            frm_phase = PH_IDLE;
            if (b == start_mark) begin
               xor_acc = b;
               frm_phase = PH_LEN;
            end
         end
      endcase
   endfunction

   function automatic void push_byte(logic [7:0] b);
      rx_stream.push_back(b);
      bytes_queued++;
   endfunction

   function automatic void queue_frame(int len, logic [7:0] cmd, flaw_type flaw);
      logic [7:0] frm [$];
      logic [7:0] sum;
      int keep;
      frm.push_back(start_mark);
      frm.push_back(8'(len));
      frm.push_back(cmd);
      for (int i = 0; i < len; i++)
         frm.push_back(8'($urandom_range(0, 255)));
      sum = 8'h00;
      foreach (frm[i])
         sum ^= frm[i];
      if (flaw == FLAW_SUM)
         sum ^= 8'($urandom_range(1, 255));
      frm.push_back(sum);
      frm.push_back((flaw == FLAW_END) ? end_mark ^ 8'($urandom_range(1, 255)) : end_mark);
      // a cut frame runs on into whatever bytes follow
      keep = (flaw == FLAW_CUT) ? $urandom_range(1, frm.size() - 1) : frm.size();
      for (int i = 0; i < keep; i++)
         push_byte(frm[i]);
      frame_bytes += keep;
      frames_sent++;
   endfunction

   function automatic void random_frames(int budget);
      int first;
      int len;
      int pick;
      logic [7:0] cmd;
      flaw_type flaw;
      first = frame_bytes;
      while (frame_bytes - first < budget) begin
         repeat ($urandom_range(0, 2))
            push_byte(8'($urandom_range(0, 255)));
         pick = $urandom_range(0, 99);
         if (pick < 70)
            len = $urandom_range(0, 4);
         else if (pick < 95)
            len = $urandom_range(5, 12);
         else
            len = $urandom_range(13, 40);
         pick = $urandom_range(0, 99);
         if (pick < 40)
            cmd = CMD_REPORT;
         else if (pick < 80)
            cmd = CMD_PWM;
         else
            cmd = 8'($urandom_range(0, 255));
         pick = $urandom_range(0, 99);
         if (pick < 75)
            flaw = FLAW_NONE;
         else if (pick < 83)
            flaw = FLAW_SUM;
         else if (pick < 91)
            flaw = FLAW_END;
         else
            flaw = FLAW_CUT;
         queue_frame(len, cmd, flaw);
      end
   endfunction

   // wait until every byte is taken and every word has come, then let the block go quiet
   task automatic settle();
      while (bytes_taken != bytes_queued || due_words.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic addr, logic [7:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      if (addr == CSR_START)
         start_mark = value;
      else
         end_mark = value;
      reg_writes++;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // byte sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         tx_wait = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            parse_byte(req_tdata);
            bytes_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (tx_wait > 0) begin
               tx_wait--;
               req_tvalid <= 1'b0;
            end else if (rx_stream.size() > 0) begin
               req_tdata <= rx_stream.pop_front();
               req_tvalid <= 1'b1;
               tx_wait = tx_burst ? 0 : $urandom_range(0, 9);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result receiver and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
         hold_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            words_seen++;
            got = '{rsp_tuser, rsp_tdata[7:0], rsp_tlast, rsp_tdata[15:8], rsp_tdata[31:16]};
            if (due_words.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected word: kind %0d reply %h last %b duty %h ticks %h",
                           got.kind, got.reply, got.last, got.duty, got.ticks);
            end else begin
               want = due_words.pop_front();
               if (got != want) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("word %0d mismatch (expected/actual): kind %0d/%0d reply %h/%h",
                              words_seen, want.kind, got.kind, want.reply, got.reply);
                     $display("   last %b/%b duty %h/%h ticks %h/%h",
                              want.last, got.last, want.duty, got.duty, want.ticks, got.ticks);
                  end
               end
            end
            stall_left = rx_burst ? 0 : $urandom_range(0, 9);
         end else if (!rsp_tready && stall_left > 0) begin
            stall_left--;
         end
         if (hold_left > 0)
            hold_left--;
         else if (hold_asks != hold_done) begin
            hold_done = hold_asks;
            hold_left = LONG_HOLD;
         end
         rsp_tready <= (stall_left == 0) && (hold_left == 0);
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset markers: noise, each command, short data, zero length, both error kinds
      push_byte(8'h00);
      push_byte(8'hFF);
      queue_frame(0, CMD_REPORT, FLAW_NONE);
      queue_frame(1, CMD_PWM, FLAW_NONE);
      queue_frame(0, 8'hFF, FLAW_NONE);
      queue_frame(0, CMD_REPORT, FLAW_END);
      queue_frame(0, 8'h00, FLAW_SUM);
      settle();
      random_frames(45);
      settle();

      // lowest start, highest end; receiver holds off while the sender bursts
      write_reg(CSR_START, 8'h00);
      write_reg(CSR_END, 8'hFF);
      tx_burst = 1;
      hold_asks++;
      random_frames(55);
      settle();
      tx_burst = 0;

      // highest start, lowest end; receiver never stalls
      write_reg(CSR_START, 8'hFF);
      write_reg(CSR_END, 8'h00);
      rx_burst = 1;
      random_frames(55);
      settle();
      rx_burst = 0;

      // random markers, with a full drain halfway
      write_reg(CSR_START, 8'($urandom_range(0, 255)));
      write_reg(CSR_END, 8'($urandom_range(0, 255)));
      random_frames(30);
      settle();
      random_frames(30);
      settle();

      $display("%0d bytes sent (%0d in %0d frames), %0d words checked, %0d register writes",
               bytes_taken, frame_bytes, frames_sent, words_seen, reg_writes);
      $display("marker pairs: reset values, 00/ff, ff/00 and one random pair; %0d errors", errors);
      if (errors == 0)
         $display("** xor_framed_command_parser_unit: PASSED **");
      else
         $display("** xor_framed_command_parser_unit: FAILED **");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d words still expected", due_words.size());
      $display("** xor_framed_command_parser_unit: FAILED **");
      $finish;
   end

endmodule

### sim.f
design/xfcp_pkg.sv
design/xfcp_parser.sv
design/xfcp_emitter.sv
design/xor_framed_command_parser_unit.sv
verif/tb_xor_framed_command_parser_unit.sv
